// File: sv/e2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_pkg: shared types, constants and microcode for the epoch converter
// Holds the request and result payloads, the control word format, the
// reciprocal and divisor tables, the month table and the sequencer program.
// ----------------------------------------------------------------------------
package e2c_pkg;

  localparam int unsigned STEP_W    = 5;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned REM_W     = 32;
  localparam int unsigned MUL_A_W   = 25;
  localparam int unsigned MUL_B_W   = 26;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned DIVISOR_W = 17;

  // Calendar year 1970 as years since 1900.
  localparam logic [7:0] YEAR_START    = 8'd70;
  localparam logic [3:0] LAST_MONTH    = 4'd11;
  localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;

  // Reciprocals of the odd part of each divisor. The power of two is shifted
  // off the dividend first; the product is then cut at a fixed bit, which
  // gives the exact quotient over the whole operand range of each step.
  //   86400 = 128 * 675, cut at bit 35
  //   3600  = 16 * 225,  cut at bit 21
  //   60    = 4 * 15,    cut at bit 14
  //   7,                 cut at bit 19
  localparam logic [MUL_B_W-1:0] RECIP_DAY  = 26'd50903317;
  localparam logic [MUL_B_W-1:0] RECIP_HOUR = 26'd9321;
  localparam logic [MUL_B_W-1:0] RECIP_MIN  = 26'd1093;
  localparam logic [MUL_B_W-1:0] RECIP_WEEK = 26'd74899;

  typedef struct packed {
    logic [31:0] epoch_seconds;
  } req_t;

  typedef struct packed {
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [8:0] day_of_year;
    logic [2:0] weekday;
  } res_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_QUO,
    OP_REM,
    OP_SAVE_DAYS,
    OP_SAVE_HOUR,
    OP_SAVE_MIN,
    OP_SAVE_WDAY,
    OP_YEAR,
    OP_SAVE_YDAY,
    OP_MONTH,
    OP_DONE
  } op_e;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WEEK
  } dsel_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_YEAR,
    C_MONTH,
    C_NOREQ,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e               op;
    dsel_e             dsel;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Program addresses.
  localparam logic [STEP_W-1:0] STEP_DAY_QUO   = 5'd0;
  localparam logic [STEP_W-1:0] STEP_DAY_REM   = 5'd1;
  localparam logic [STEP_W-1:0] STEP_SAVE_DAYS = 5'd2;
  localparam logic [STEP_W-1:0] STEP_HOUR_QUO  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_HOUR_REM  = 5'd4;
  localparam logic [STEP_W-1:0] STEP_SAVE_HOUR = 5'd5;
  localparam logic [STEP_W-1:0] STEP_MIN_QUO   = 5'd6;
  localparam logic [STEP_W-1:0] STEP_MIN_REM   = 5'd7;
  localparam logic [STEP_W-1:0] STEP_SAVE_MIN  = 5'd8;
  localparam logic [STEP_W-1:0] STEP_WEEK_QUO  = 5'd9;
  localparam logic [STEP_W-1:0] STEP_WEEK_REM  = 5'd10;
  localparam logic [STEP_W-1:0] STEP_SAVE_WDAY = 5'd11;
  localparam logic [STEP_W-1:0] STEP_YEAR      = 5'd12;
  localparam logic [STEP_W-1:0] STEP_SAVE_YDAY = 5'd13;
  localparam logic [STEP_W-1:0] STEP_MONTH     = 5'd14;
  localparam logic [STEP_W-1:0] STEP_DONE      = 5'd15;
  // Idle sits at the top so that falling through wraps to the first step.
  localparam logic [STEP_W-1:0] STEP_IDLE      = 5'd31;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Divisor of each step, used to form the remainder from the quotient.
  function automatic logic [DIVISOR_W-1:0] divisor(input dsel_e sel);
    logic [DIVISOR_W-1:0] d;
    unique case (sel)
      DIV_DAY:  d = 17'd86400;
      DIV_HOUR: d = 17'd3600;
      DIV_MIN:  d = 17'd60;
      DIV_WEEK: d = 17'd7;
      default:  d = 17'd1;
    endcase
    return d;
  endfunction

  function automatic logic [MUL_B_W-1:0] recip(input dsel_e sel);
    logic [MUL_B_W-1:0] r;
    unique case (sel)
      DIV_DAY:  r = RECIP_DAY;
      DIV_HOUR: r = RECIP_HOUR;
      DIV_MIN:  r = RECIP_MIN;
      DIV_WEEK: r = RECIP_WEEK;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // Gregorian rule over years 1970 to 2106: 2000 is a leap year, 2100 is not.
  function automatic logic is_leap(input logic [7:0] yr);
    return (yr[1:0] == 2'd0) && (yr != 8'd200);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = (mon <= LAST_MONTH) ? MONTH_LEN[mon] : 5'd31;
    if (mon == 4'd1 && leap) begin
      len = 5'd29;
    end
    return len;
  endfunction

  // Sequencer program. Next step is target when the condition holds,
  // otherwise the following address.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    unique case (step)
      STEP_DAY_QUO:   cw = '{OP_QUO,       DIV_DAY,  C_NEVER,    STEP_IDLE};
      STEP_DAY_REM:   cw = '{OP_REM,       DIV_DAY,  C_NEVER,    STEP_IDLE};
      STEP_SAVE_DAYS: cw = '{OP_SAVE_DAYS, DIV_DAY,  C_NEVER,    STEP_IDLE};
      STEP_HOUR_QUO:  cw = '{OP_QUO,       DIV_HOUR, C_NEVER,    STEP_IDLE};
      STEP_HOUR_REM:  cw = '{OP_REM,       DIV_HOUR, C_NEVER,    STEP_IDLE};
      STEP_SAVE_HOUR: cw = '{OP_SAVE_HOUR, DIV_DAY,  C_NEVER,    STEP_IDLE};
      STEP_MIN_QUO:   cw = '{OP_QUO,       DIV_MIN,  C_NEVER,    STEP_IDLE};
      STEP_MIN_REM:   cw = '{OP_REM,       DIV_MIN,  C_NEVER,    STEP_IDLE};
      STEP_SAVE_MIN:  cw = '{OP_SAVE_MIN,  DIV_DAY,  C_NEVER,    STEP_IDLE};
      STEP_WEEK_QUO:  cw = '{OP_QUO,       DIV_WEEK, C_NEVER,    STEP_IDLE};
      STEP_WEEK_REM:  cw = '{OP_REM,       DIV_WEEK, C_NEVER,    STEP_IDLE};
      STEP_SAVE_WDAY: cw = '{OP_SAVE_WDAY, DIV_DAY,  C_NEVER,    STEP_IDLE};
      STEP_YEAR:      cw = '{OP_YEAR,      DIV_DAY,  C_YEAR,     STEP_YEAR};
      STEP_SAVE_YDAY: cw = '{OP_SAVE_YDAY, DIV_DAY,  C_NEVER,    STEP_IDLE};
      STEP_MONTH:     cw = '{OP_MONTH,     DIV_DAY,  C_MONTH,    STEP_MONTH};
      STEP_DONE:      cw = '{OP_DONE,      DIV_DAY,  C_OUT_BUSY, STEP_DONE};
      STEP_IDLE:      cw = '{OP_IDLE,      DIV_DAY,  C_NOREQ,    STEP_IDLE};
      default:        cw = '{OP_NOP,       DIV_DAY,  C_ALWAYS,   STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// File: sv/e2c_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_req_if: request channel of the epoch converter
// Valid/ready handshake carrying one epoch second count.
// ----------------------------------------------------------------------------
interface e2c_req_if;
  logic          valid;
  logic          ready;
  e2c_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/e2c_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_res_if: result channel of the epoch converter
// Valid/ready handshake carrying one broken-down calendar date and time.
// ----------------------------------------------------------------------------
interface e2c_res_if;
  logic          valid;
  logic          ready;
  e2c_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top: epoch seconds to UTC calendar converter
// A microcoded sequencer turns an unsigned seconds count into year, month,
// day, time of day, day of year and weekday.
// ----------------------------------------------------------------------------
//
//   Port    Dir   Handshake     Carries
//   req_i   in    valid/ready   epoch_seconds (32 bits)
//   res_o   out   valid/ready   years, month, day, hour, minute, second,
//                               day of year, weekday
//
// A request runs the program from acceptance to a result in the output
// register: each of the four divisions is a quotient step and a remainder
// step, then a save step; then come the year walk, one subtract of a year
// length per cycle, the month walk and the final step that loads the
// result. A no-op step and the idle step follow, and only then can the
// next request be taken.
// Requests are taken one at a time, only while the sequencer is idle; a
// result waiting in the output register does not hold off the next request.
// If the output register is still full when a new result is ready, the
// sequencer waits in its final step. Reset returns it to idle and empties
// the output register.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  e2c_req_if.sink       req_i,
  e2c_res_if.source     res_o
);

  // Sequencer state: the step counter and the current control word.
  logic [e2c_pkg::STEP_W-1:0] pc_q, pc_d;
  e2c_pkg::ctrl_t             cw;

  // Datapath registers. The remainder register carries the dividend of each
  // division and then the day count through the year and month walks.
  logic [e2c_pkg::REM_W-1:0] rem_q, rem_d;
  logic [e2c_pkg::QUO_W-1:0] quo_q, quo_d;
  logic [15:0]               days_q, days_d;
  logic [4:0]                hour_q, hour_d;
  logic [5:0]                min_q, min_d;
  logic [5:0]                sec_q, sec_d;
  logic [2:0]                wday_q, wday_d;
  logic [7:0]                yr_q, yr_d;
  logic [8:0]                yday_q, yday_d;
  logic [3:0]                mon_q, mon_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  e2c_pkg::res_t out_q, out_d;

  logic                                          req_fire;
  logic                                          out_busy;
  logic [e2c_pkg::MUL_A_W-1:0]                   mul_a;
  logic [e2c_pkg::PROD_W-1:0]                    prod;
  logic [e2c_pkg::QUO_W-1:0]                     quo_est;
  logic [e2c_pkg::QUO_W+e2c_pkg::DIVISOR_W-1:0]  back_prod;
  logic                                          leap;
  logic [8:0]                                    year_len;
  logic                                          year_more;
  logic [4:0]                                    mon_len;
  logic                                          month_more;
  logic                                          jump;

  assign cw = e2c_pkg::ucode(pc_q);

  assign req_i.ready   = (cw.op == e2c_pkg::OP_IDLE);
  assign req_fire      = req_i.valid && req_i.ready;
  assign out_busy      = out_valid_q && !res_o.ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  // Reciprocal divider. The power-of-two part of the divisor is dropped from
  // the dividend, the rest is multiplied by the reciprocal of the odd part,
  // and the quotient is read at a fixed bit of the product.
  always_comb begin
    case (cw.dsel)
      e2c_pkg::DIV_DAY:  mul_a = rem_q[31:7];
      e2c_pkg::DIV_HOUR: mul_a = {12'd0, rem_q[16:4]};
      e2c_pkg::DIV_MIN:  mul_a = {15'd0, rem_q[11:2]};
      e2c_pkg::DIV_WEEK: mul_a = {9'd0, rem_q[15:0]};
      default:           mul_a = '0;
    endcase
  end

  assign prod = {{e2c_pkg::MUL_B_W{1'b0}}, mul_a} *
                {{e2c_pkg::MUL_A_W{1'b0}}, e2c_pkg::recip(cw.dsel)};

  always_comb begin
    case (cw.dsel)
      e2c_pkg::DIV_DAY:  quo_est = prod[50:35];
      e2c_pkg::DIV_HOUR: quo_est = prod[36:21];
      e2c_pkg::DIV_MIN:  quo_est = prod[29:14];
      e2c_pkg::DIV_WEEK: quo_est = prod[34:19];
      default:           quo_est = '0;
    endcase
  end

  // The remainder step takes quotient times divisor off the dividend.
  assign back_prod = {{e2c_pkg::DIVISOR_W{1'b0}}, quo_q} *
                     {{e2c_pkg::QUO_W{1'b0}}, e2c_pkg::divisor(cw.dsel)};

  assign leap       = e2c_pkg::is_leap(yr_q);
  assign year_len   = leap ? 9'd366 : 9'd365;
  assign year_more  = (rem_q >= 32'(year_len));
  assign mon_len    = e2c_pkg::month_len(mon_q, leap);
  assign month_more = (mon_q != e2c_pkg::LAST_MONTH) && (rem_q >= 32'(mon_len));

  // Jump condition selected by the control word.
  always_comb begin
    case (cw.cond)
      e2c_pkg::C_NEVER:    jump = 1'b0;
      e2c_pkg::C_ALWAYS:   jump = 1'b1;
      e2c_pkg::C_YEAR:     jump = year_more;
      e2c_pkg::C_MONTH:    jump = month_more;
      e2c_pkg::C_NOREQ:    jump = !req_fire;
      e2c_pkg::C_OUT_BUSY: jump = out_busy;
      default:             jump = 1'b0;
    endcase
  end

  assign pc_d = jump ? cw.target : e2c_pkg::STEP_W'(pc_q + 1'b1);

  // Datapath, driven by the operation field.
  always_comb begin
    rem_d       = rem_q;
    quo_d       = quo_q;
    days_d      = days_q;
    hour_d      = hour_q;
    min_d       = min_q;
    sec_d       = sec_q;
    wday_d      = wday_q;
    yr_d        = yr_q;
    yday_d      = yday_q;
    mon_d       = mon_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;

    unique case (cw.op)
      e2c_pkg::OP_IDLE: begin
        if (req_fire) begin
          rem_d = req_i.payload.epoch_seconds;
        end
      end
      e2c_pkg::OP_QUO: begin
        quo_d = quo_est;
      end
      e2c_pkg::OP_REM: begin
        rem_d = rem_q - back_prod[e2c_pkg::REM_W-1:0];
      end
      e2c_pkg::OP_SAVE_DAYS: begin
        // The remainder is now the second of the day.
        days_d = quo_q;
      end
      e2c_pkg::OP_SAVE_HOUR: begin
        hour_d = quo_q[4:0];
      end
      e2c_pkg::OP_SAVE_MIN: begin
        // Set up the weekday division: 1970-01-01 was a Thursday.
        min_d = quo_q[5:0];
        sec_d = rem_q[5:0];
        rem_d = 32'(days_q) + 32'(e2c_pkg::EPOCH_WEEKDAY);
      end
      e2c_pkg::OP_SAVE_WDAY: begin
        wday_d = rem_q[2:0];
        rem_d  = 32'(days_q);
        yr_d   = e2c_pkg::YEAR_START;
      end
      e2c_pkg::OP_YEAR: begin
        if (year_more) begin
          rem_d = rem_q - 32'(year_len);
          yr_d  = yr_q + 8'd1;
        end
      end
      e2c_pkg::OP_SAVE_YDAY: begin
        yday_d = rem_q[8:0];
        mon_d  = 4'd0;
      end
      e2c_pkg::OP_MONTH: begin
        if (month_more) begin
          rem_d = rem_q - 32'(mon_len);
          mon_d = mon_q + 4'd1;
        end
      end
      e2c_pkg::OP_DONE: begin
        if (!out_busy) begin
          out_valid_d            = 1'b1;
          out_d.years_since_1900 = yr_q;
          out_d.month_index      = mon_q;
          out_d.day_of_month     = rem_q[4:0] + 5'd1;
          out_d.hour_of_day      = hour_q;
          out_d.minute_of_hour   = min_q;
          out_d.second_of_minute = sec_q;
          out_d.day_of_year      = yday_q;
          out_d.weekday          = wday_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= e2c_pkg::STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    days_q <= days_d;
    hour_q <= hour_d;
    min_q  <= min_d;
    sec_q  <= sec_d;
    wday_q <= wday_d;
    yr_q   <= yr_d;
    yday_q <= yday_d;
    mon_q  <= mon_d;
    out_q  <= out_d;
  end

endmodule
